FILE: design/type_a_anticollision_select_defines.svh
// Assertion macros for the type A anticollision select block.
// Used by the port checker; no other dependencies.
`ifndef TYPE_A_ANTICOLLISION_SELECT_DEFINES_SVH
`define TYPE_A_ANTICOLLISION_SELECT_DEFINES_SVH

// implication checked on every rising edge outside reset
`define TAS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in one cycle implies the consequence in the next
`define TAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

FILE: design/tas_pkg.sv
// Package for the type A anticollision select block.
// Shared codes, widths and the CRC_A byte step; no dependencies.
package tas_pkg;

  localparam int unsigned FrameBytes = 9;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_RXB   = 2'd2,
    CMD_END   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0,
    KIND_UID   = 2'd1,
    KIND_FIN   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_INTERNAL = 3'd2,
    ST_UNRES    = 3'd3,
    ST_FRAME    = 3'd4,
    ST_CRC      = 3'd5,
    ST_TIMEOUT  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    RX_OK   = 2'd0,
    RX_COLL = 2'd1,
    RX_TMO  = 2'd2,
    RX_ERR  = 2'd3
  } rxst_e;

  localparam logic [7:0] CascadeTag = 8'h88;
  localparam logic [7:0] NvbSelect  = 8'h70;
  localparam logic [7:0] SakCascade = 8'h04;
  localparam logic [15:0] CrcPreset = 16'h6363;
  localparam logic [6:0] MaxKnown   = 7'd80;

  // one CRC_A byte update
  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [7:0] ch;
    ch = b ^ crc[7:0];
    ch = ch ^ {ch[3:0], 4'b0};
    return {8'h00, crc[15:8]} ^ {ch, 8'h00} ^ {5'b0, ch, 3'b0} ^ {12'h000, ch[7:4]};
  endfunction

endpackage

FILE: design/tas_crc.sv
// Shared CRC_A unit: one byte per cycle while en_i is high, restarted by the sequencer.
// Depends on tas_pkg.
module tas_crc (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       clr_i,
  input  logic       en_i,
  input  logic [7:0] byte_i,
  output logic [15:0] crc_o
);
  import tas_pkg::*;
  logic [15:0] crc_q, crc_d;

  always_comb begin
    crc_d = crc_q;
    if (clr_i) crc_d = CrcPreset;
    else if (en_i) crc_d = crc_step(crc_q, byte_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) crc_q <= CrcPreset;
    else crc_q <= crc_d;
  end

  assign crc_o = crc_q;
endmodule

FILE: design/type_a_anticollision_select.sv
// Top level of the type A anticollision select block: sequencer, frame
// buffer, uid store. Depends on tas_pkg and tas_crc.
//
//  channel | direction | words
//  in      | to block  | command, uid, known bits, response bytes, status
//  out     | from block| frame bytes, found uid bytes, finish status
//
// A load or response byte is taken with no output. A start or response end
// that does not finish at once runs the sequencer: S_LEVEL builds a level,
// S_CRC finishes a frame (anticollision, or SELECT with CRC over 7 bytes),
// S_SCRC and S_SAK check the SAK CRC, and S_SEND or S_UID emits the output
// words (at most 10), each only after the one before it is taken.
// Reset: idle, cascade level 1. in_ready_o is low while the sequencer runs or
// a word waits on out; an out stall holds the sequencer.
module type_a_anticollision_select #(
  parameter int unsigned UID_BYTES = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  input  logic [3:0] uid_index_i,
  input  logic [7:0] uid_value_i,
  input  logic [6:0] known_bits_i,
  input  logic [3:0] size_hint_i,
  input  logic [7:0] rx_byte_i,
  input  logic [1:0] rx_status_i,
  input  logic       coll_pos_valid_i,
  input  logic [4:0] coll_pos_i,
  input  logic [2:0] rx_last_bits_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] data_byte_o,
  output logic [2:0] tx_last_bits_o,
  output logic       last_o,
  output logic [2:0] status_o,
  output logic [7:0] sak_o,
  output logic [3:0] uid_size_o
);
  import tas_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LEVEL = 7'b0000010,
    S_CRC   = 7'b0000100,
    S_SEND  = 7'b0001000,
    S_SCRC  = 7'b0010000,
    S_SAK   = 7'b0100000,
    S_UID   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [7:0] uid_q [UID_BYTES];
  logic [7:0] fb_q [FrameBytes];
  logic [1:0] lvl_q;
  logic [5:0] lkb_q;
  logic [6:0] skb_q;
  logic [3:0] sizeb_q;
  logic [3:0] rxc_q;
  logic       busy_q;      // awaiting response
  logic [3:0] cnt_q;       // byte counter for crc / send / uid
  logic [3:0] used_q;
  logic [2:0] txl_q;
  logic       ov_q;
  logic [1:0] okind_q;
  logic [7:0] odata_q, osak_q;
  logic [2:0] otxl_q, ost_q;
  logic       olast_q;
  logic [3:0] osize_q;

  logic [15:0] crc;
  logic crc_clr, crc_en;
  logic [7:0] crc_byte;

  tas_crc u_crc (
    .clk_i, .rst_ni, .clr_i(crc_clr), .en_i(crc_en), .byte_i(crc_byte), .crc_o(crc)
  );

  function automatic logic [7:0] uid_rd(logic [7:0] a [UID_BYTES], logic [3:0] i);
    logic [7:0] r;
    r = 8'h00;
    for (int j = 0; j < UID_BYTES; j++) if (i == 4'(j)) r = a[j];
    return r;
  endfunction

  wire acc = in_valid_i && in_ready_o;
  wire oacc = out_valid_o && out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && !ov_q;

  // response geometry
  logic [3:0] rstart, rcap;
  always_comb begin
    rstart = (lkb_q >= 6'd32) ? 4'd6 : 4'(4'd2 + 4'(lkb_q[5:3]));
    rcap   = (lkb_q >= 6'd32) ? 4'd3 : 4'(4'(FrameBytes) - rstart);
  end

  wire [3:0] base = 4'(4'd3 * 4'(lvl_q - 2'd1));
  wire [3:0] usize = 4'(4'd3 * 4'(lvl_q) + 4'd1);

  assign crc_clr  = (state_q == S_IDLE) || (state_q == S_LEVEL);
  assign crc_en   = (state_q == S_CRC) || (state_q == S_SCRC);
  assign crc_byte = (state_q == S_SCRC) ? fb_q[6] : fb_q[cnt_q[3:0] < 4'd9 ? cnt_q : 4'd0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; lvl_q <= 2'd1; lkb_q <= '0; skb_q <= '0; sizeb_q <= '0;
      rxc_q <= '0; busy_q <= 1'b0; cnt_q <= '0; used_q <= '0; txl_q <= '0; ov_q <= 1'b0;
    end else begin
      if (oacc) ov_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (acc) begin
          unique case (cmd_e'(command_i))
            CMD_LOAD: for (int j = 0; j < UID_BYTES; j++)
              if (uid_index_i == 4'(j)) uid_q[j] <= uid_value_i;
            CMD_START: begin
              if (known_bits_i > MaxKnown) begin
                busy_q <= 1'b0;
                ov_q <= 1'b1; okind_q <= KIND_FIN; odata_q <= '0; otxl_q <= '0;
                olast_q <= 1'b1; ost_q <= ST_INVALID; osak_q <= '0; osize_q <= '0;
              end else begin
                skb_q <= known_bits_i; sizeb_q <= size_hint_i; lvl_q <= 2'd1;
                for (int j = 0; j < FrameBytes; j++) fb_q[j] <= 8'h00;
                state_q <= S_LEVEL;
              end
            end
            CMD_RXB: if (busy_q) begin
              if (rxc_q < rcap && (rstart + rxc_q) < 4'd9) begin
                for (int j = 0; j < FrameBytes; j++)
                  if (rstart + rxc_q == 4'(j)) begin
                    if (rxc_q == 0 && lkb_q < 6'd32 && lkb_q[2:0] != 0)
                      fb_q[j] <= (fb_q[j] & ~(8'hFF << lkb_q[2:0]))
                               | (rx_byte_i & (8'hFF << lkb_q[2:0]));
                    else fb_q[j] <= rx_byte_i;
                  end
              end
              if (rxc_q < 4'd15) rxc_q <= rxc_q + 4'd1;
            end
            CMD_END: if (busy_q) begin
              logic fin;
              logic [2:0] st;
              logic [5:0] pos;
              fin = 1'b0; st = ST_OK;
              pos = (coll_pos_i == 0) ? 6'd32 : {1'b0, coll_pos_i};
              if (rx_status_i == RX_TMO) begin fin = 1; st = ST_TIMEOUT; end
              else if (rx_status_i == RX_ERR || rxc_q > rcap) begin fin = 1; st = ST_FRAME; end
              else if (rx_status_i == RX_COLL) begin
                if (!coll_pos_valid_i) begin fin = 1; st = ST_UNRES; end
                else if (pos <= lkb_q) begin fin = 1; st = ST_INTERNAL; end
                else begin
                  lkb_q <= pos;
                  for (int j = 2; j < FrameBytes; j++)
                    if (4'd2 + 4'((pos - 6'd1) >> 3) == 4'(j))
                      fb_q[j][3'(pos - 6'd1)] <= 1'b1;
                  state_q <= S_CRC; cnt_q <= '0;
                end
              end else if (lkb_q < 6'd32) begin
                lkb_q <= 6'd32; state_q <= S_CRC; cnt_q <= '0;
              end else begin
                for (int c = 0; c < 4; c++) begin
                  if (fb_q[2] == CascadeTag) begin
                    if (c < 3)
                      for (int j = 0; j < UID_BYTES; j++)
                        if (base + 4'(c) == 4'(j)) uid_q[j] <= fb_q[3 + c];
                  end else
                    for (int j = 0; j < UID_BYTES; j++)
                      if (base + 4'(c) == 4'(j)) uid_q[j] <= fb_q[2 + c];
                end
                if (rxc_q != 4'd3 || rx_last_bits_i != 0) begin fin = 1; st = ST_FRAME; end
                else state_q <= S_SCRC;
              end
              if (fin) begin
                busy_q <= 1'b0;
                ov_q <= 1'b1; okind_q <= KIND_FIN; odata_q <= '0; otxl_q <= '0;
                olast_q <= 1'b1; ost_q <= st; osak_q <= '0; osize_q <= '0;
              end
            end
            default: ;
          endcase
        end
        S_LEVEL: begin
          logic ct;
          logic [6:0] k;
          logic [3:0] idx, nb, mb;
          ct = skb_q != 0 && ((lvl_q == 2'd1 && sizeb_q > 4'd4) ||
                              (lvl_q == 2'd2 && sizeb_q > 4'd7));
          k = (skb_q > 7'(8 * base)) ? 7'(skb_q - 7'(8 * base)) : 7'd0;
          nb = 4'((k + 7'd7) >> 3);
          mb = ct ? 4'd3 : 4'd4;
          if (nb > mb) nb = mb;
          idx = ct ? 4'd3 : 4'd2;
          fb_q[0] <= (lvl_q == 2'd1) ? 8'h93 : ((lvl_q == 2'd2) ? 8'h95 : 8'h97);
          if (ct) fb_q[2] <= CascadeTag;
          for (int c = 0; c < 4; c++)
            if (4'(c) < nb)
              for (int j = 2; j < 6; j++)
                if (idx + 4'(c) == 4'(j)) fb_q[j] <= uid_rd(uid_q, base + 4'(c));
          if (ct) k = k + 7'd8;
          if (k > 7'd32) k = 7'd32;
          lkb_q <= k[5:0];
          state_q <= S_CRC; cnt_q <= '0;
        end
        S_CRC: begin
          if (lkb_q < 6'd32) begin
            fb_q[1] <= {4'(4'd2 + 4'(lkb_q[5:3])), 1'b0, lkb_q[2:0]};
            txl_q <= lkb_q[2:0];
            used_q <= 4'(4'd2 + 4'(lkb_q[5:3])) + ((lkb_q[2:0] != 0) ? 4'd1 : 4'd0);
            state_q <= S_SEND; cnt_q <= '0;
          end else if (cnt_q == 4'd0) begin
            fb_q[1] <= NvbSelect;
            fb_q[6] <= fb_q[2] ^ fb_q[3] ^ fb_q[4] ^ fb_q[5];
            cnt_q <= 4'd1;
          end else if (cnt_q < 4'd7) cnt_q <= cnt_q + 4'd1;
          else begin
            fb_q[7] <= crc[7:0]; fb_q[8] <= crc[15:8];
            txl_q <= '0; used_q <= 4'd9; state_q <= S_SEND; cnt_q <= '0;
          end
        end
        S_SEND: if (!ov_q) begin
          ov_q <= 1'b1; okind_q <= KIND_FRAME; odata_q <= fb_q[cnt_q]; otxl_q <= txl_q;
          olast_q <= (cnt_q + 4'd1 == used_q); ost_q <= ST_OK; osak_q <= '0; osize_q <= '0;
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q + 4'd1 == used_q) begin
            state_q <= S_IDLE; busy_q <= 1'b1; rxc_q <= '0;
          end
        end
        S_SCRC: state_q <= S_SAK;
        S_SAK: begin
          if (fb_q[7] != crc[7:0] || fb_q[8] != crc[15:8] ||
              (fb_q[6] & SakCascade) != 0 && lvl_q == 2'd3) begin
            busy_q <= 1'b0; state_q <= S_IDLE;
            ov_q <= 1'b1; okind_q <= KIND_FIN; odata_q <= '0; otxl_q <= '0; olast_q <= 1'b1;
            ost_q <= (fb_q[7] != crc[7:0] || fb_q[8] != crc[15:8]) ? ST_CRC : ST_INTERNAL;
            osak_q <= '0; osize_q <= '0;
          end else if ((fb_q[6] & SakCascade) != 0) begin
            lvl_q <= lvl_q + 2'd1; state_q <= S_LEVEL;
          end else begin
            sizeb_q <= usize; busy_q <= 1'b0; state_q <= S_UID; cnt_q <= '0;
          end
        end
        S_UID: if (!ov_q) begin
          ov_q <= 1'b1; okind_q <= KIND_UID; odata_q <= uid_rd(uid_q, cnt_q); otxl_q <= '0;
          olast_q <= (cnt_q + 4'd1 == usize); ost_q <= ST_OK; osak_q <= fb_q[6];
          osize_q <= usize; cnt_q <= cnt_q + 4'd1;
          if (cnt_q + 4'd1 == usize) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = ov_q;
  assign kind_o = okind_q;
  assign data_byte_o = odata_q;
  assign tx_last_bits_o = otxl_q;
  assign last_o = olast_q;
  assign status_o = ost_q;
  assign sak_o = osak_q;
  assign uid_size_o = osize_q;
endmodule

FILE: design/tas_checker.sv
// Port checker for the type A anticollision select block, bound to the top.
// Depends on tas_pkg and the assertion macro header.
`include "type_a_anticollision_select_defines.svh"
module tas_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] kind_o,
  input logic [7:0] data_byte_o,
  input logic       last_o,
  input logic [2:0] status_o,
  input logic [3:0] uid_size_o
);
  import tas_pkg::*;
  `TAS_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(data_byte_o) && $stable(kind_o), "out word dropped")
  `TAS_ASSERT(a_fin, clk_i, rst_ni, out_valid_o && kind_o == KIND_FIN |-> last_o && data_byte_o == 8'h00, "bad finish word")
  `TAS_ASSERT(a_uid, clk_i, rst_ni, out_valid_o && kind_o == KIND_UID |-> (uid_size_o == 4'd4 || uid_size_o == 4'd7 || uid_size_o == 4'd10) && status_o == ST_OK, "bad uid word")
  `TAS_ASSERT(a_kind, clk_i, rst_ni, out_valid_o |-> kind_o != 2'd3, "bad kind")
  `TAS_ASSERT(a_rdy, clk_i, rst_ni, in_ready_o |-> !out_valid_o, "ready while word waits")
endmodule

bind type_a_anticollision_select tas_checker u_tas_checker (.*);

FILE: verif/tb.sv
// Testbench for type_a_anticollision_select: directed table, then random
// anticollision/select sessions checked against an in-bench predictor.
// Depends on tas_pkg and the RTL top level only.
module tb;
  import tas_pkg::*;

  typedef struct {
    cmd_e        cmd;
    logic [3:0]  idx;
    logic [7:0]  val;
    logic [6:0]  kb;
    logic [3:0]  hint;
    logic [7:0]  rxb;
    rxst_e       rst;
    logic        cpv;
    logic [4:0]  cpos;
    logic [2:0]  lb;
  } word_t;

  typedef struct {
    kind_e       kind;
    logic [7:0]  data;
    logic [2:0]  txl;
    logic        last;
    status_e     status;
    logic [7:0]  sak;
    logic [3:0]  size;
  } res_t;

  typedef struct {
    word_t       w;
    bit          chk;
    kind_e       ekind;
    status_e     estat;
    logic [7:0]  edata;
  } row_t;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic in_valid_i = 1'b0, out_ready_i = 1'b0;
  logic in_ready_o, out_valid_o, last_o;
  logic [1:0] command_i = '0, rx_status_i = '0, kind_o;
  logic [3:0] uid_index_i = '0, size_hint_i = '0, uid_size_o;
  logic [7:0] uid_value_i = '0, rx_byte_i = '0, data_byte_o, sak_o;
  logic [6:0] known_bits_i = '0;
  logic       coll_pos_valid_i = 1'b0;
  logic [4:0] coll_pos_i = '0;
  logic [2:0] rx_last_bits_i = '0, tx_last_bits_o, status_o;

  type_a_anticollision_select u_top (.*);

  always #1 clk_i = ~clk_i;

  res_t pending_q[$];
  int   errors = 0;
  bit   gaps_on = 1'b1;
  int   words_sent = 0;
  // first result predicted for the word last sent
  res_t first_r;
  bit   first_ok = 1'b0;

  // predictor state
  logic [7:0]  uid_mem[10];
  logic [7:0]  fbuf[9];
  int          lvl = 1, lkb = 0, skb = 0, belief = 0, rxc = 0;
  bit          busy = 1'b0;

  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [15:0] crc_a_update(logic [15:0] crc, logic [7:0] b);
    crc ^= {8'h00, b};
    for (int i = 0; i < 8; i++)
      crc = crc[0] ? ((crc >> 1) ^ 16'h8408) : (crc >> 1);
    return crc;
  endfunction

  function automatic logic [7:0] uid_rd(int i);
    return (i < 10) ? uid_mem[i] : 8'h00;
  endfunction

  function automatic void push(kind_e k, logic [7:0] d, logic [2:0] t, logic l,
                               status_e s, logic [7:0] sk, logic [3:0] sz);
    res_t r;
    r.kind = k; r.data = d; r.txl = t; r.last = l; r.status = s; r.sak = sk; r.size = sz;
    pending_q.push_back(r);
  endfunction

  function automatic void finish_run(status_e s);
    busy = 1'b0;
    push(KIND_FIN, 8'h00, 3'd0, 1'b1, s, 8'h00, 4'd0);
  endfunction

  function automatic void send_frame();
    int used, txl, idx;
    logic [15:0] crc;
    if (lkb >= 32) begin
      fbuf[1] = NvbSelect;
      fbuf[6] = fbuf[2] ^ fbuf[3] ^ fbuf[4] ^ fbuf[5];
      crc = CrcPreset;
      for (int i = 0; i < 7; i++) crc = crc_a_update(crc, fbuf[i]);
      fbuf[7] = crc[7:0];
      fbuf[8] = crc[15:8];
      txl = 0;
      used = 9;
    end else begin
      idx = 2 + lkb / 8;
      txl = lkb % 8;
      fbuf[1] = 8'((idx << 4) + txl);
      used = idx + (txl != 0);
    end
    rxc = 0;
    busy = 1'b1;
    for (int i = 0; i < used; i++)
      push(KIND_FRAME, fbuf[i], 3'(txl), i + 1 == used, ST_OK, 8'h00, 4'd0);
  endfunction

  function automatic void begin_level();
    int base, k, idx, nbytes, maxb;
    bit ct;
    base = 3 * (lvl - 1);
    k = 0;
    idx = 2;
    fbuf[0] = (lvl == 1) ? 8'h93 : ((lvl == 2) ? 8'h95 : 8'h97);
    ct = skb != 0 && ((lvl == 1 && belief > 4) || (lvl == 2 && belief > 7));
    if (skb > 8 * base) k = skb - 8 * base;
    if (ct) fbuf[idx++] = CascadeTag;
    nbytes = (k + 7) / 8;
    maxb = ct ? 3 : 4;
    if (nbytes > maxb) nbytes = maxb;
    for (int c = 0; c < nbytes; c++) fbuf[idx++] = uid_rd(base + c);
    if (ct) k += 8;
    if (k > 32) k = 32;
    lkb = k;
    send_frame();
  endfunction

  // works out the results of one accepted word
  function automatic void predict_word(word_t w);
    int rs, cap, align, p, base, pos, src, cnt, sz;
    logic [7:0] mask;
    logic [15:0] crc;
    rs = (lkb >= 32) ? 6 : 2 + lkb / 8;
    cap = (lkb >= 32) ? 3 : 9 - rs;
    base = 3 * (lvl - 1);
    case (w.cmd)
      CMD_LOAD: if (w.idx < 10) uid_mem[w.idx] = w.val;
      CMD_START: begin
        if (w.kb > MaxKnown) begin
          finish_run(ST_INVALID);
        end else begin
          skb = w.kb;
          belief = w.hint;
          lvl = 1;
          foreach (fbuf[i]) fbuf[i] = 8'h00;
          begin_level();
        end
      end
      CMD_RXB: if (busy) begin
        align = (lkb >= 32) ? 0 : lkb % 8;
        if (rxc < cap) begin
          p = rs + rxc;
          if (rxc == 0 && align != 0) begin
            mask = 8'hFF << align;
            fbuf[p] = (fbuf[p] & ~mask) | (w.rxb & mask);
          end else begin
            fbuf[p] = w.rxb;
          end
        end
        if (rxc < 15) rxc++;
      end
      default: if (busy) begin
        if (w.rst == RX_TMO) finish_run(ST_TIMEOUT);
        else if (w.rst == RX_ERR || rxc > cap) finish_run(ST_FRAME);
        else if (w.rst == RX_COLL) begin
          pos = (w.cpos == 0) ? 32 : w.cpos;
          if (!w.cpv) finish_run(ST_UNRES);
          else if (pos <= lkb) finish_run(ST_INTERNAL);
          else begin
            lkb = pos;
            fbuf[2 + (pos - 1) / 8][(pos - 1) % 8] = 1'b1;
            send_frame();
          end
        end else if (lkb < 32) begin
          lkb = 32;
          send_frame();
        end else begin
          src = (fbuf[2] == CascadeTag) ? 3 : 2;
          cnt = (fbuf[2] == CascadeTag) ? 3 : 4;
          for (int c = 0; c < cnt; c++)
            if (base + c < 10) uid_mem[base + c] = fbuf[src + c];
          crc = crc_a_update(CrcPreset, fbuf[6]);
          if (rxc != 3 || w.lb != 0) finish_run(ST_FRAME);
          else if (fbuf[7] != crc[7:0] || fbuf[8] != crc[15:8]) finish_run(ST_CRC);
          else if ((fbuf[6] & SakCascade) != 0) begin
            if (lvl >= 3) finish_run(ST_INTERNAL);
            else begin
              lvl++;
              begin_level();
            end
          end else begin
            sz = 3 * lvl + 1;
            belief = sz;
            busy = 1'b0;
            for (int c = 0; c < sz; c++)
              push(KIND_UID, uid_rd(c), 3'd0, c + 1 == sz, ST_OK, fbuf[6], 4'(sz));
          end
        end
      end
    endcase
  endfunction

  task automatic send_word(word_t w);
    int n0;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    n0 = pending_q.size();
    predict_word(w);
    first_ok = pending_q.size() > n0;
    if (first_ok) first_r = pending_q[n0];
    command_i <= w.cmd;          uid_index_i <= w.idx;
    uid_value_i <= w.val;        known_bits_i <= w.kb;
    size_hint_i <= w.hint;       rx_byte_i <= w.rxb;
    rx_status_i <= w.rst;        coll_pos_valid_i <= w.cpv;
    coll_pos_i <= w.cpos;        rx_last_bits_i <= w.lb;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  function automatic word_t mk(cmd_e c, int idx, int val, int kb, int hint,
                               rxst_e s, int cpv, int cpos, int lb);
    word_t w;
    w.cmd = c; w.idx = 4'(idx); w.val = 8'(val); w.kb = 7'(kb); w.hint = 4'(hint);
    w.rxb = 8'(val); w.rst = s; w.cpv = cpv[0]; w.cpos = 5'(cpos); w.lb = 3'(lb);
    return w;
  endfunction

  function automatic word_t rnd_word(cmd_e c);
    word_t w;
    w = mk(c, $urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 127),
           $urandom_range(0, 10), rxst_e'($urandom_range(0, 3)), $urandom_range(0, 1),
           $urandom_range(0, 31), $urandom_range(0, 7));
    return w;
  endfunction

  // card answer to a SELECT: SAK then CRC_A, low byte first
  task automatic answer_select(logic [7:0] sak, bit bad_crc);
    logic [15:0] crc;
    crc = crc_a_update(CrcPreset, sak);
    if (bad_crc) crc ^= 16'(1 << $urandom_range(0, 15));
    send_word(mk(CMD_RXB, 0, sak, 0, 0, RX_OK, 0, 0, 0));
    send_word(mk(CMD_RXB, 0, crc[7:0], 0, 0, RX_OK, 0, 0, 0));
    send_word(mk(CMD_RXB, 0, crc[15:8], 0, 0, RX_OK, 0, 0, 0));
    send_word(mk(CMD_END, 0, 0, 0, 0, RX_OK, 0, 0, 0));
  endtask

  task automatic random_session();
    word_t w;
    int n, cap, r;
    logic [7:0] sak;
    repeat ($urandom_range(0, 3)) send_word(rnd_word(CMD_LOAD));
    if (!busy && $urandom_range(0, 7) == 0)
      send_word(rnd_word(cmd_e'($urandom_range(2, 3))));
    w = rnd_word(CMD_START);
    r = $urandom_range(0, 9);
    if (r == 0) w.kb = 7'($urandom_range(81, 127));
    else if (r < 4) w.kb = 7'(8 * $urandom_range(0, 10));
    else w.kb = 7'($urandom_range(0, 80));
    send_word(w);
    for (int round = 0; round < 10 && busy; round++) begin
      if ($urandom_range(0, 24) == 0) break;      // abandoned: next start restarts
      r = $urandom_range(0, 99);
      if (lkb >= 32) begin
        if (r < 85) begin
          sak = 8'($urandom_range(0, 255));
          if (lvl == 3 && $urandom_range(0, 3) != 0) sak &= ~SakCascade;
          else if ($urandom_range(0, 1) == 0) sak |= SakCascade;
          answer_select(sak, $urandom_range(0, 9) == 0);
          continue;
        end
        n = $urandom_range(0, 4);
      end else begin
        cap = 9 - (2 + lkb / 8);
        n = (r < 80) ? cap : $urandom_range(0, cap + 1);
      end
      repeat (n) send_word(rnd_word(CMD_RXB));
      w = rnd_word(CMD_END);
      r = $urandom_range(0, 99);
      if (r < 65) begin
        w.rst = RX_OK;
        w.lb = 3'd0;
      end else if (r < 88 && lkb < 32) begin
        w.rst = RX_COLL;
        w.cpv = 1'b1;
        w.cpos = 5'($urandom_range(lkb + 1, 32));
      end
      send_word(w);
    end
  endtask

  row_t tab[25];

  initial begin
    int nrow;
    logic [7:0] ld[10];
    logic [15:0] crc;
    ld = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC};
    nrow = 0;
    foreach (ld[i]) tab[nrow++] = '{mk(CMD_LOAD, i, ld[i], 0, 0, RX_OK, 0, 0, 0),
                                    0, KIND_FRAME, ST_OK, 8'h00};
    tab[nrow++] = '{mk(CMD_START, 0, 0, 127, 10, RX_OK, 0, 0, 0), 1, KIND_FIN, ST_INVALID, 8'h00};
    tab[nrow++] = '{mk(CMD_START, 0, 0, 0, 4, RX_OK, 0, 0, 0), 1, KIND_FRAME, ST_OK, 8'h93};
    tab[nrow++] = '{mk(CMD_END, 0, 0, 0, 0, RX_TMO, 0, 0, 0), 1, KIND_FIN, ST_TIMEOUT, 8'h00};
    tab[nrow++] = '{mk(CMD_START, 0, 0, 0, 4, RX_OK, 0, 0, 0), 1, KIND_FRAME, ST_OK, 8'h93};
    tab[nrow++] = '{mk(CMD_END, 0, 0, 0, 0, RX_ERR, 0, 0, 0), 1, KIND_FIN, ST_FRAME, 8'h00};
    tab[nrow++] = '{mk(CMD_START, 0, 0, 0, 4, RX_OK, 0, 0, 0), 1, KIND_FRAME, ST_OK, 8'h93};
    tab[nrow++] = '{mk(CMD_END, 0, 0, 0, 0, RX_COLL, 0, 3, 0), 1, KIND_FIN, ST_UNRES, 8'h00};
    tab[nrow++] = '{mk(CMD_START, 0, 0, 0, 0, RX_OK, 0, 0, 0), 1, KIND_FRAME, ST_OK, 8'h93};
    // position 0 means bit 32
    tab[nrow++] = '{mk(CMD_END, 0, 0, 0, 0, RX_COLL, 1, 0, 0), 1, KIND_FRAME, ST_OK, 8'h93};
    tab[nrow++] = '{mk(CMD_END, 0, 0, 0, 0, RX_COLL, 1, 5, 0), 1, KIND_FIN, ST_INTERNAL, 8'h00};
    tab[nrow++] = '{mk(CMD_START, 0, 0, 32, 4, RX_OK, 0, 0, 0), 1, KIND_FRAME, ST_OK, 8'h93};
    crc = crc_a_update(CrcPreset, 8'h00);
    tab[nrow++] = '{mk(CMD_RXB, 0, 8'h00, 0, 0, RX_OK, 0, 0, 0), 0, KIND_FRAME, ST_OK, 8'h00};
    tab[nrow++] = '{mk(CMD_RXB, 0, crc[7:0], 0, 0, RX_OK, 0, 0, 0), 0, KIND_FRAME, ST_OK, 8'h00};
    tab[nrow++] = '{mk(CMD_RXB, 0, crc[15:8], 0, 0, RX_OK, 0, 0, 0), 0, KIND_FRAME, ST_OK, 8'h00};
    tab[nrow++] = '{mk(CMD_END, 0, 0, 0, 0, RX_OK, 0, 0, 0), 1, KIND_UID, ST_OK, 8'h00};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < nrow; i++) begin
      send_word(tab[i].w);
      if (tab[i].chk && (!first_ok ||
          first_r.kind != tab[i].ekind || first_r.status != tab[i].estat ||
          first_r.data != tab[i].edata))
        report($sformatf("directed row %0d: predicted result differs from table", i));
    end
    while (words_sent < 460) begin
      if (words_sent > 400) gaps_on = 1'b0;
      random_session();
    end
    in_valid_i <= 1'b0;
    gaps_on = 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

  initial begin
    #400000;
    $display("tb NOT OK");
    $finish;
  end

  // receiver: random stall bursts, one long hold-off mid-run
  int rx_cycles = 0, stall_left = 0;
  always @(posedge clk_i) begin
    rx_cycles++;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (rx_cycles >= 600 && rx_cycles < 900) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected word kind=%0d data=%02h", kind_o, data_byte_o));
      end else begin
        exp_r = pending_q.pop_front();
        if (kind_o !== exp_r.kind || data_byte_o !== exp_r.data ||
            tx_last_bits_o !== exp_r.txl || last_o !== exp_r.last ||
            status_o !== exp_r.status || sak_o !== exp_r.sak || uid_size_o !== exp_r.size)
          report($sformatf(
            "got k%0d d%02h t%0d l%0d s%0d sak%02h sz%0d, want k%0d d%02h t%0d l%0d s%0d sak%02h sz%0d",
            kind_o, data_byte_o, tx_last_bits_o, last_o, status_o, sak_o, uid_size_o,
            exp_r.kind, exp_r.data, exp_r.txl, exp_r.last, exp_r.status, exp_r.sak,
            exp_r.size));
      end
    end
  end

endmodule

FILE: filelist.f
+incdir+design
design/tas_pkg.sv
design/tas_crc.sv
design/type_a_anticollision_select.sv
design/tas_checker.sv
verif/tb.sv
